FILE: rtl/ihsr_pkg.sv
// Shared types, constants and helpers for the I2C humidity sensor reader.
`default_nettype none
package ihsr_pkg;

   localparam int CNT_W = 24;

   // conversion constants, results in hundredths
   localparam logic [14:0] TEMP_SPAN   = 15'd17500;
   localparam logic [14:0] TEMP_OFFSET = 15'd4500;
   localparam logic [13:0] HUM_SPAN    = 14'd10000;
   localparam logic [15:0] ROUND_HALF  = 16'd32767;
   localparam logic [15:0] FULL_SCALE  = 16'hFFFF;

   typedef enum logic [2:0] {
      CSR_DEVICE_ADDRESS = 3'd0,
      CSR_COMMAND_HIGH   = 3'd1,
      CSR_COMMAND_LOW    = 3'd2,
      CSR_HALF_PERIOD    = 3'd3,
      CSR_ACK_TIMEOUT    = 3'd4,
      CSR_CONV_WAIT      = 3'd5,
      CSR_RETRY_WAIT     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [6:0]  device_address;
      logic [7:0]  command_high;
      logic [7:0]  command_low;
      logic [15:0] half_period_ticks;
      logic [7:0]  ack_timeout;
      logic [23:0] conversion_wait_ticks;
      logic [23:0] retry_wait_ticks;
   } cfg_type;

   typedef struct packed {
      logic clock_line;
      logic data_line;
      logic data_drive_enable;
      logic busy_res;
      logic done_res;
      logic failed;
   } pins_type;

   // floor(p / 65535) for p below 2^31: estimate by shift, then one correction
   function automatic logic [14:0] div_full_scale(input logic [30:0] p);
      logic [14:0] q_est;
      logic [16:0] rem;
      begin
         q_est = p[30:16];
         rem   = {1'b0, p[15:0]} + {2'b00, q_est};
         if (rem >= {1'b0, FULL_SCALE}) begin
            div_full_scale = q_est + 15'd1;
         end else begin
            div_full_scale = q_est;
         end
      end
   endfunction

endpackage
`default_nettype wire

FILE: rtl/ihsr_convert.sv
// Two-stage conversion of raw sensor words into hundredths.
`default_nettype none
module ihsr_convert (
   input  wire logic        clock,
   input  wire logic [15:0] temperature_raw,
   input  wire logic [15:0] humidity_raw,
   output logic [14:0]      temperature_q,
   output logic [13:0]      humidity_q
);

   logic [30:0] t_prod_ff, t_prod_in;
   logic [29:0] h_prod_ff, h_prod_in;
   logic [14:0] t_q_ff, t_q_in;
   logic [13:0] h_q_ff, h_q_in;
   logic [14:0] h_div;

   // raw words settle many items before the done item, so free-running is enough
   assign t_prod_in = 31'(temperature_raw * ihsr_pkg::TEMP_SPAN)
                    + {15'd0, ihsr_pkg::ROUND_HALF};
   assign h_prod_in = 30'(humidity_raw * ihsr_pkg::HUM_SPAN)
                    + {14'd0, ihsr_pkg::ROUND_HALF};

   assign t_q_in = ihsr_pkg::div_full_scale(t_prod_ff);
   assign h_div  = ihsr_pkg::div_full_scale({1'b0, h_prod_ff});
   assign h_q_in = h_div[13:0];

   always_ff @(posedge clock) begin
      t_prod_ff <= t_prod_in;
      h_prod_ff <= h_prod_in;
      t_q_ff    <= t_q_in;
      h_q_ff    <= h_q_in;
   end

   assign temperature_q = t_q_ff;
   assign humidity_q    = h_q_ff;

endmodule
`default_nettype wire

FILE: rtl/ihsr_engine.sv
// Bus sequencer: one tick per step, pin levels registered as the result.
`default_nettype none
module ihsr_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic              start_request,
   input  wire logic              sda_sample,
   input  wire ihsr_pkg::cfg_type cfg,
   output ihsr_pkg::pins_type     pins,
   output logic [15:0]            temperature_raw,
   output logic [15:0]            humidity_raw
);

   typedef enum logic [4:0] {
      PH_IDLE, PH_START_A, PH_START_B, PH_WR_LOW, PH_WR_HIGH,
      PH_ACK_LOW, PH_ACK_HIGH, PH_ACK_POLL, PH_RD_LOW, PH_RD_HIGH,
      PH_MA_LOW, PH_MA_HIGH, PH_STOP_A, PH_STOP_B, PH_STOP_C,
      PH_CONV_WAIT, PH_RETRY_WAIT, PH_DONE, PH_FAIL
   } phase_type;

   typedef enum logic [1:0] {
      TGT_FAIL, TGT_CONV, TGT_RETRY, TGT_DONE
   } target_type;

   phase_type   phase_ff, phase_in;
   target_type  target_ff, target_in;
   logic        poll_ff, poll_in;
   logic [ihsr_pkg::CNT_W-1:0] tick_ff, tick_in;
   logic [3:0]  bit_ff, bit_in;
   logic [2:0]  byte_ff, byte_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  ackcnt_ff, ackcnt_in;
   logic [15:0] temp_ff, temp_in;
   logic [15:0] hum_ff, hum_in;
   ihsr_pkg::pins_type pins_ff, pins_in;

   logic [ihsr_pkg::CNT_W-1:0] dur_raw, dur_eff, seg_next;
   logic [ihsr_pkg::CNT_W:0]   cnt_inc;
   logic        seg_done;
   logic [3:0]  bit_inc;
   logic [7:0]  rd_byte;
   logic        acked, ack_resolve;

   always_comb begin
      case (phase_ff)
         PH_CONV_WAIT:  dur_raw = ihsr_pkg::CNT_W'(cfg.conversion_wait_ticks);
         PH_RETRY_WAIT: dur_raw = ihsr_pkg::CNT_W'(cfg.retry_wait_ticks);
         default:       dur_raw = ihsr_pkg::CNT_W'(cfg.half_period_ticks);
      endcase
   end

   // a zero duration still lasts one tick
   assign dur_eff  = (dur_raw == '0) ? ihsr_pkg::CNT_W'(1) : dur_raw;
   assign cnt_inc  = {1'b0, tick_ff} + {{ihsr_pkg::CNT_W{1'b0}}, 1'b1};
   assign seg_done = cnt_inc >= {1'b0, dur_eff};
   assign seg_next = seg_done ? '0 : cnt_inc[ihsr_pkg::CNT_W-1:0];
   assign bit_inc  = bit_ff + 4'd1;
   assign rd_byte  = {shift_ff[6:0], sda_sample};
   assign acked    = !sda_sample;
   assign ack_resolve = acked || (ackcnt_ff >= cfg.ack_timeout);

   always_comb begin
      phase_in  = phase_ff;
      target_in = target_ff;
      poll_in   = poll_ff;
      tick_in   = tick_ff;
      bit_in    = bit_ff;
      byte_in   = byte_ff;
      shift_in  = shift_ff;
      ackcnt_in = ackcnt_ff;
      temp_in   = temp_ff;
      hum_in    = hum_ff;

      case (phase_ff)
         PH_IDLE, PH_DONE, PH_FAIL: begin
            if (start_request) begin
               poll_in  = 1'b0;
               byte_in  = '0;
               tick_in  = '0;
               phase_in = PH_START_A;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_START_A: begin
            tick_in = seg_next;
            if (seg_done) phase_in = PH_START_B;
         end
         PH_START_B: begin
            tick_in = seg_next;
            if (seg_done) begin
               shift_in = {cfg.device_address, poll_ff};
               bit_in   = '0;
               phase_in = PH_WR_LOW;
            end
         end
         PH_WR_LOW: begin
            tick_in = seg_next;
            if (seg_done) phase_in = PH_WR_HIGH;
         end
         PH_WR_HIGH: begin
            tick_in = seg_next;
            if (seg_done) begin
               shift_in = {shift_ff[6:0], 1'b0};
               bit_in   = bit_inc;
               phase_in = (bit_inc >= 4'd8) ? PH_ACK_LOW : PH_WR_LOW;
            end
         end
         PH_ACK_LOW: begin
            tick_in = seg_next;
            if (seg_done) phase_in = PH_ACK_HIGH;
         end
         PH_ACK_HIGH: begin
            tick_in = seg_next;
            if (seg_done) begin
               ackcnt_in = '0;
               phase_in  = PH_ACK_POLL;
            end
         end
         PH_ACK_POLL: begin
            if (ack_resolve) begin
               tick_in = '0;
               if (poll_ff) begin
                  if (acked) begin
                     byte_in  = '0;
                     shift_in = '0;
                     bit_in   = '0;
                     phase_in = PH_RD_LOW;
                  end else begin
                     target_in = TGT_RETRY;
                     phase_in  = PH_STOP_A;
                  end
               end else if (byte_ff == 3'd0) begin
                  if (acked) begin
                     byte_in  = 3'd1;
                     shift_in = cfg.command_high;
                     bit_in   = '0;
                     phase_in = PH_WR_LOW;
                  end else begin
                     target_in = TGT_FAIL;
                     phase_in  = PH_STOP_A;
                  end
               end else if (byte_ff == 3'd1) begin
                  // refusal of the first command byte is ignored
                  byte_in  = 3'd2;
                  shift_in = cfg.command_low;
                  bit_in   = '0;
                  phase_in = PH_WR_LOW;
               end else begin
                  target_in = acked ? TGT_CONV : TGT_FAIL;
                  phase_in  = PH_STOP_A;
               end
            end else begin
               ackcnt_in = ackcnt_ff + 8'd1;
            end
         end
         PH_RD_LOW: begin
            tick_in = seg_next;
            if (seg_done) phase_in = PH_RD_HIGH;
         end
         PH_RD_HIGH: begin
            tick_in = seg_next;
            if (seg_done) begin
               shift_in = rd_byte;
               bit_in   = bit_inc;
               if (bit_inc >= 4'd8) begin
                  case (byte_ff)
                     3'd0:    temp_in = {rd_byte, temp_ff[7:0]};
                     3'd1:    temp_in = {temp_ff[15:8], rd_byte};
                     3'd3:    hum_in  = {rd_byte, hum_ff[7:0]};
                     3'd4:    hum_in  = {hum_ff[15:8], rd_byte};
                     default: ;
                  endcase
                  phase_in = PH_MA_LOW;
               end else begin
                  phase_in = PH_RD_LOW;
               end
            end
         end
         PH_MA_LOW: begin
            tick_in = seg_next;
            if (seg_done) phase_in = PH_MA_HIGH;
         end
         PH_MA_HIGH: begin
            tick_in = seg_next;
            if (seg_done) begin
               if (byte_ff >= 3'd5) begin
                  target_in = TGT_DONE;
                  phase_in  = PH_STOP_A;
               end else begin
                  byte_in  = byte_ff + 3'd1;
                  shift_in = '0;
                  bit_in   = '0;
                  phase_in = PH_RD_LOW;
               end
            end
         end
         PH_STOP_A: begin
            tick_in = seg_next;
            if (seg_done) phase_in = PH_STOP_B;
         end
         PH_STOP_B: begin
            tick_in = seg_next;
            if (seg_done) phase_in = PH_STOP_C;
         end
         PH_STOP_C: begin
            tick_in = seg_next;
            if (seg_done) begin
               case (target_ff)
                  TGT_CONV:  phase_in = PH_CONV_WAIT;
                  TGT_RETRY: phase_in = PH_RETRY_WAIT;
                  TGT_DONE:  phase_in = PH_DONE;
                  default:   phase_in = PH_FAIL;
               endcase
            end
         end
         PH_CONV_WAIT, PH_RETRY_WAIT: begin
            tick_in = seg_next;
            if (seg_done) begin
               poll_in  = 1'b1;
               byte_in  = '0;
               phase_in = PH_START_A;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            tick_in  = '0;
         end
      endcase
   end

   // pin levels follow the updated phase
   always_comb begin
      pins_in = '{clock_line: 1'b1, data_line: 1'b0, data_drive_enable: 1'b0,
                  busy_res: 1'b1, done_res: 1'b0, failed: 1'b0};
      case (phase_in)
         PH_START_A: begin
            pins_in.data_line = 1'b1;
            pins_in.data_drive_enable = 1'b1;
         end
         PH_START_B, PH_STOP_B: pins_in.data_drive_enable = 1'b1;
         PH_WR_LOW: begin
            pins_in.clock_line = 1'b0;
            pins_in.data_line = shift_in[7];
            pins_in.data_drive_enable = 1'b1;
         end
         PH_WR_HIGH: begin
            pins_in.data_line = shift_in[7];
            pins_in.data_drive_enable = 1'b1;
         end
         PH_ACK_LOW, PH_RD_LOW: pins_in.clock_line = 1'b0;
         PH_MA_LOW: begin
            pins_in.clock_line = 1'b0;
            pins_in.data_line = (byte_in >= 3'd5);
            pins_in.data_drive_enable = 1'b1;
         end
         PH_MA_HIGH: begin
            pins_in.data_line = (byte_in >= 3'd5);
            pins_in.data_drive_enable = 1'b1;
         end
         PH_STOP_A: begin
            pins_in.clock_line = 1'b0;
            pins_in.data_drive_enable = 1'b1;
         end
         PH_STOP_C: begin
            pins_in.data_line = 1'b1;
            pins_in.data_drive_enable = 1'b1;
         end
         PH_IDLE:  pins_in.busy_res = 1'b0;
         PH_DONE: begin
            pins_in.busy_res = 1'b0;
            pins_in.done_res = 1'b1;
         end
         PH_FAIL: begin
            pins_in.busy_res = 1'b0;
            pins_in.failed = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         target_ff <= TGT_FAIL;
         poll_ff   <= 1'b0;
         tick_ff   <= '0;
         bit_ff    <= '0;
         byte_ff   <= '0;
         shift_ff  <= '0;
         ackcnt_ff <= '0;
         temp_ff   <= '0;
         hum_ff    <= '0;
         pins_ff   <= '{clock_line: 1'b1, data_line: 1'b0, data_drive_enable: 1'b0,
                        busy_res: 1'b0, done_res: 1'b0, failed: 1'b0};
      end else if (step) begin
         phase_ff  <= phase_in;
         target_ff <= target_in;
         poll_ff   <= poll_in;
         tick_ff   <= tick_in;
         bit_ff    <= bit_in;
         byte_ff   <= byte_in;
         shift_ff  <= shift_in;
         ackcnt_ff <= ackcnt_in;
         temp_ff   <= temp_in;
         hum_ff    <= hum_in;
         pins_ff   <= pins_in;
      end
   end

   assign pins            = pins_ff;
   assign temperature_raw = temp_ff;
   assign humidity_raw    = hum_ff;

endmodule
`default_nettype wire

FILE: rtl/i2c_humidity_sensor_reader.sv
// An accepted item is held in the input register, then steps the sequencer into the result register.
// Throughput: one item per cycle while the result is not stalled; each item is one bus timing tick.
// A stalled result holds the sequencer; the input register takes one more item, then stalls.
// Conversion runs in two free-running stages fed by the stored raw words.
// Synchronous reset: sequencer idle, no item held, configuration registers at defaults.
`default_nettype none
module i2c_humidity_sensor_reader (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_start_request,
   input  wire logic               req_sda_sample,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_clock_line,
   output logic                    rsp_data_line,
   output logic                    rsp_data_drive_enable,
   output logic                    rsp_busy_res,
   output logic                    rsp_done_res,
   output logic                    rsp_failed,
   output logic signed [14:0]      rsp_temperature_centi,
   output logic [13:0]             rsp_humidity_centi,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [23:0]        csr_data
);

   ihsr_pkg::cfg_type  cfg_ff, cfg_in;
   ihsr_pkg::pins_type pins;
   logic        in_valid_ff, in_valid_in;
   logic        in_start_ff, in_sda_ff;
   logic        out_valid_ff, out_valid_in;
   logic        step, accept;
   logic [15:0] temperature_raw, humidity_raw;
   logic [14:0] temperature_q;
   logic [13:0] humidity_q;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (ihsr_pkg::csr_index_type'(csr_index))
            ihsr_pkg::CSR_DEVICE_ADDRESS: cfg_in.device_address = csr_data[6:0];
            ihsr_pkg::CSR_COMMAND_HIGH:   cfg_in.command_high = csr_data[7:0];
            ihsr_pkg::CSR_COMMAND_LOW:    cfg_in.command_low = csr_data[7:0];
            ihsr_pkg::CSR_HALF_PERIOD:    cfg_in.half_period_ticks = csr_data[15:0];
            ihsr_pkg::CSR_ACK_TIMEOUT:    cfg_in.ack_timeout = csr_data[7:0];
            ihsr_pkg::CSR_CONV_WAIT:      cfg_in.conversion_wait_ticks = csr_data;
            ihsr_pkg::CSR_RETRY_WAIT:     cfg_in.retry_wait_ticks = csr_data;
            default: ;
         endcase
      end
   end

   // held item advances when the result slot is empty or draining
   assign step        = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall   = in_valid_ff && !step;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign out_valid_in = step ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{device_address: 7'd68, command_high: 8'd44, command_low: 8'd6,
                     half_period_ticks: 16'd100, ack_timeout: 8'd250,
                     conversion_wait_ticks: 24'd50000,
                     retry_wait_ticks: 24'd100000};
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_start_ff <= req_start_request;
         in_sda_ff   <= req_sda_sample;
      end
   end

   ihsr_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .start_request   (in_start_ff),
      .sda_sample      (in_sda_ff),
      .cfg             (cfg_ff),
      .pins            (pins),
      .temperature_raw (temperature_raw),
      .humidity_raw    (humidity_raw)
   );

   ihsr_convert u_convert (
      .clock           (clock),
      .temperature_raw (temperature_raw),
      .humidity_raw    (humidity_raw),
      .temperature_q   (temperature_q),
      .humidity_q      (humidity_q)
   );

   assign rsp_valid             = out_valid_ff;
   assign rsp_clock_line        = pins.clock_line;
   assign rsp_data_line         = pins.data_line;
   assign rsp_data_drive_enable = pins.data_drive_enable;
   assign rsp_busy_res          = pins.busy_res;
   assign rsp_done_res          = pins.done_res;
   assign rsp_failed            = pins.failed;
   // results read zero outside the done item
   assign rsp_temperature_centi = pins.done_res
                                ? signed'(temperature_q - ihsr_pkg::TEMP_OFFSET)
                                : 15'sd0;
   assign rsp_humidity_centi    = pins.done_res ? humidity_q : 14'd0;

endmodule
`default_nettype wire

FILE: rtl/ihsr_checker.sv
// Port-level checks for the I2C humidity sensor reader, bound to the top level.
`default_nettype none
module ihsr_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic               rsp_clock_line,
   input wire logic               rsp_data_line,
   input wire logic               rsp_data_drive_enable,
   input wire logic               rsp_busy_res,
   input wire logic               rsp_done_res,
   input wire logic               rsp_failed,
   input wire logic signed [14:0] rsp_temperature_centi,
   input wire logic [13:0]        rsp_humidity_centi
);

   a_done_fail_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_done_res && rsp_failed))
      else $error("done and failed at once");

   a_end_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_done_res || rsp_failed)) |-> !rsp_busy_res)
      else $error("busy during done or failed item");

   a_released_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data_drive_enable) |-> !rsp_data_line)
      else $error("data level set while line released");

   a_results_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_done_res) |->
         (rsp_temperature_centi == 15'sd0 && rsp_humidity_centi == 14'd0))
      else $error("results nonzero outside done item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_clock_line) && $stable(rsp_data_line)
          && $stable(rsp_done_res) && $stable(rsp_temperature_centi)))
      else $error("stalled result changed");

endmodule

bind i2c_humidity_sensor_reader ihsr_checker u_ihsr_checker (.*);
`default_nettype wire

FILE: verif/i2c_humidity_sensor_reader_test.sv
// Self-checking testbench for the I2C humidity sensor reader, predicted tick by tick.
`default_nettype none
module i2c_humidity_sensor_reader_test;

   typedef enum logic [4:0] {
      S_IDLE, S_START_A, S_START_B, S_WR_LOW, S_WR_HIGH, S_ACK_LOW, S_ACK_HIGH,
      S_ACK_POLL, S_RD_LOW, S_RD_HIGH, S_MA_LOW, S_MA_HIGH, S_STOP_A, S_STOP_B,
      S_STOP_C, S_CONV_WAIT, S_RETRY_WAIT, S_DONE, S_FAIL
   } seq_phase_type;

   typedef enum logic [1:0] {
      AFTER_FAIL, AFTER_CONV, AFTER_RETRY, AFTER_DONE
   } stop_target_type;

   typedef enum {ACK_AT_ONCE, ACK_LATE, ACK_NEVER} ack_style_type;
   typedef enum {BITS_RANDOM, BITS_LOW, BITS_HIGH} data_style_type;

   typedef struct packed {
      ihsr_pkg::pins_type pins;
      logic signed [14:0] temp;
      logic [13:0]        hum;
   } bus_result_type;

   typedef struct packed {
      logic               start;
      logic               sda;
      logic               typed;
      ihsr_pkg::pins_type pins;
      logic signed [14:0] temp;
      logic [13:0]        hum;
   } tick_row_type;

   // scl, sda, sda_en, busy, done, failed
   localparam ihsr_pkg::pins_type PINS_IDLE  = 6'b100000;
   localparam ihsr_pkg::pins_type PINS_START = 6'b111100;

   localparam int ROWS = 8;
   tick_row_type tick_rows [0:ROWS-1] = '{
      '{1'b0, 1'b0, 1'b1, PINS_IDLE,  15'sd0, 14'd0},
      '{1'b0, 1'b1, 1'b1, PINS_IDLE,  15'sd0, 14'd0},
      '{1'b1, 1'b1, 1'b1, PINS_START, 15'sd0, 14'd0},
      '{1'b1, 1'b0, 1'b1, PINS_START, 15'sd0, 14'd0},
      '{1'b0, 1'b1, 1'b1, PINS_START, 15'sd0, 14'd0},
      '{1'b0, 1'b0, 1'b0, PINS_IDLE,  15'sd0, 14'd0},
      '{1'b1, 1'b1, 1'b0, PINS_IDLE,  15'sd0, 14'd0},
      '{1'b0, 1'b0, 1'b0, PINS_IDLE,  15'sd0, 14'd0}
   };

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_start_request = 1'b0;
   logic                    req_sda_sample = 1'b1;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_clock_line;
   logic                    rsp_data_line;
   logic                    rsp_data_drive_enable;
   logic                    rsp_busy_res;
   logic                    rsp_done_res;
   logic                    rsp_failed;
   logic signed [14:0]      rsp_temperature_centi;
   logic [13:0]             rsp_humidity_centi;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   ihsr_pkg::csr_index_type csr_index = ihsr_pkg::CSR_DEVICE_ADDRESS;
   logic [23:0]             csr_data = 24'd0;

   i2c_humidity_sensor_reader dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_start_request     (req_start_request),
      .req_sda_sample        (req_sda_sample),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_clock_line        (rsp_clock_line),
      .rsp_data_line         (rsp_data_line),
      .rsp_data_drive_enable (rsp_data_drive_enable),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_done_res          (rsp_done_res),
      .rsp_failed            (rsp_failed),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 120000);
      $display("Mismatches found");
      $finish;
   end

   // ---------------- sequencer model ----------------
   ihsr_pkg::cfg_type cfg;
   seq_phase_type     ph;
   logic [23:0]       tick_cnt;
   logic [3:0]        bit_cnt;
   logic [2:0]        byte_cnt;
   logic [7:0]        shreg;
   logic [7:0]        ack_polls;
   logic [15:0]       t_raw;
   logic [15:0]       h_raw;
   logic              poll_rd;
   stop_target_type   stop_tgt;

   bus_result_type    pending_bus_states [$];
   int                mismatch_count = 0;
   bit                calm = 1'b0;
   ack_style_type     ack_style = ACK_AT_ONCE;
   data_style_type    data_style = BITS_RANDOM;

   initial begin
      cfg = '{device_address: 7'd68, command_high: 8'd44, command_low: 8'd6,
              half_period_ticks: 16'd100, ack_timeout: 8'd250,
              conversion_wait_ticks: 24'd50000, retry_wait_ticks: 24'd100000};
      ph = S_IDLE;
      tick_cnt = '0;
      bit_cnt = '0;
      byte_cnt = '0;
      shreg = '0;
      ack_polls = '0;
      t_raw = '0;
      h_raw = '0;
      poll_rd = 1'b0;
      stop_tgt = AFTER_FAIL;
   end

   // one tick of a timed segment; a zero length lasts one tick
   function automatic bit seg_done(input logic [23:0] d);
      logic [23:0] len;
      len = (d == 24'd0) ? 24'd1 : d;
      if ({1'b0, tick_cnt} + 25'd1 >= {1'b0, len}) begin
         tick_cnt = '0;
         return 1'b1;
      end
      tick_cnt = tick_cnt + 24'd1;
      return 1'b0;
   endfunction

   function automatic void begin_byte_out(input logic [7:0] b);
      shreg = b;
      bit_cnt = '0;
      tick_cnt = '0;
      ph = S_WR_LOW;
   endfunction

   function automatic void begin_stop_seq(input stop_target_type tgt);
      stop_tgt = tgt;
      tick_cnt = '0;
      ph = S_STOP_A;
   endfunction

   function automatic void begin_byte_in();
      shreg = '0;
      bit_cnt = '0;
      tick_cnt = '0;
      ph = S_RD_LOW;
   endfunction

   function automatic void begin_frame(input logic rd);
      poll_rd = rd;
      byte_cnt = '0;
      tick_cnt = '0;
      ph = S_START_A;
   endfunction

   function automatic void resolve_ack(input bit acked);
      tick_cnt = '0;
      if (poll_rd) begin
         if (acked) begin
            byte_cnt = '0;
            begin_byte_in();
         end else begin
            begin_stop_seq(AFTER_RETRY);
         end
      end else if (byte_cnt == 3'd0) begin
         if (acked) begin
            byte_cnt = 3'd1;
            begin_byte_out(cfg.command_high);
         end else begin
            begin_stop_seq(AFTER_FAIL);
         end
      end else if (byte_cnt == 3'd1) begin
         // a refused first command byte is ignored
         byte_cnt = 3'd2;
         begin_byte_out(cfg.command_low);
      end else begin
         begin_stop_seq(acked ? AFTER_CONV : AFTER_FAIL);
      end
   endfunction

   function automatic bus_result_type advance_sequencer(input logic start, input logic sda);
      bus_result_type    r;
      logic [23:0]       halfp;
      longint unsigned   tq;
      longint unsigned   hq;
      halfp = {8'd0, cfg.half_period_ticks};
      case (ph)
         S_IDLE, S_DONE, S_FAIL: begin
            if (start) begin_frame(1'b0);
            else ph = S_IDLE;
         end
         S_START_A: if (seg_done(halfp)) ph = S_START_B;
         S_START_B: if (seg_done(halfp)) begin_byte_out({cfg.device_address, poll_rd});
         S_WR_LOW: if (seg_done(halfp)) ph = S_WR_HIGH;
         S_WR_HIGH: begin
            if (seg_done(halfp)) begin
               shreg = shreg << 1;
               bit_cnt = bit_cnt + 4'd1;
               ph = (bit_cnt >= 4'd8) ? S_ACK_LOW : S_WR_LOW;
            end
         end
         S_ACK_LOW: if (seg_done(halfp)) ph = S_ACK_HIGH;
         S_ACK_HIGH: begin
            if (seg_done(halfp)) begin
               ack_polls = '0;
               ph = S_ACK_POLL;
            end
         end
         S_ACK_POLL: begin
            if (!sda) resolve_ack(1'b1);
            else if (ack_polls >= cfg.ack_timeout) resolve_ack(1'b0);
            else ack_polls = ack_polls + 8'd1;
         end
         S_RD_LOW: if (seg_done(halfp)) ph = S_RD_HIGH;
         S_RD_HIGH: begin
            if (seg_done(halfp)) begin
               shreg = {shreg[6:0], sda};
               bit_cnt = bit_cnt + 4'd1;
               if (bit_cnt >= 4'd8) begin
                  // bytes 2 and 5 carry CRC and are dropped
                  case (byte_cnt)
                     3'd0: t_raw[15:8] = shreg;
                     3'd1: t_raw[7:0] = shreg;
                     3'd3: h_raw[15:8] = shreg;
                     3'd4: h_raw[7:0] = shreg;
                     default: ;
                  endcase
                  ph = S_MA_LOW;
               end else begin
                  ph = S_RD_LOW;
               end
            end
         end
         S_MA_LOW: if (seg_done(halfp)) ph = S_MA_HIGH;
         S_MA_HIGH: begin
            if (seg_done(halfp)) begin
               if (byte_cnt >= 3'd5) begin
                  begin_stop_seq(AFTER_DONE);
               end else begin
                  byte_cnt = byte_cnt + 3'd1;
                  begin_byte_in();
               end
            end
         end
         S_STOP_A: if (seg_done(halfp)) ph = S_STOP_B;
         S_STOP_B: if (seg_done(halfp)) ph = S_STOP_C;
         S_STOP_C: begin
            if (seg_done(halfp)) begin
               case (stop_tgt)
                  AFTER_CONV:  ph = S_CONV_WAIT;
                  AFTER_RETRY: ph = S_RETRY_WAIT;
                  AFTER_DONE:  ph = S_DONE;
                  default:     ph = S_FAIL;
               endcase
            end
         end
         S_CONV_WAIT: if (seg_done(cfg.conversion_wait_ticks)) begin_frame(1'b1);
         S_RETRY_WAIT: if (seg_done(cfg.retry_wait_ticks)) begin_frame(1'b1);
         default: begin
            ph = S_IDLE;
            tick_cnt = '0;
         end
      endcase

      r = '0;
      r.pins.clock_line = 1'b1;
      case (ph)
         S_START_A: begin
            r.pins.data_line = 1'b1;
            r.pins.data_drive_enable = 1'b1;
         end
         S_START_B, S_STOP_B: r.pins.data_drive_enable = 1'b1;
         S_WR_LOW: begin
            r.pins.clock_line = 1'b0;
            r.pins.data_line = shreg[7];
            r.pins.data_drive_enable = 1'b1;
         end
         S_WR_HIGH: begin
            r.pins.data_line = shreg[7];
            r.pins.data_drive_enable = 1'b1;
         end
         S_ACK_LOW, S_RD_LOW: r.pins.clock_line = 1'b0;
         S_MA_LOW: begin
            r.pins.clock_line = 1'b0;
            r.pins.data_line = (byte_cnt >= 3'd5);
            r.pins.data_drive_enable = 1'b1;
         end
         S_MA_HIGH: begin
            r.pins.data_line = (byte_cnt >= 3'd5);
            r.pins.data_drive_enable = 1'b1;
         end
         S_STOP_A: begin
            r.pins.clock_line = 1'b0;
            r.pins.data_drive_enable = 1'b1;
         end
         S_STOP_C: begin
            r.pins.data_line = 1'b1;
            r.pins.data_drive_enable = 1'b1;
         end
         default: ;
      endcase
      r.pins.busy_res = !(ph == S_IDLE || ph == S_DONE || ph == S_FAIL);
      r.pins.done_res = (ph == S_DONE);
      r.pins.failed = (ph == S_FAIL);
      if (ph == S_DONE) begin
         tq = (longint'(t_raw) * 17500 + 32767) / 65535;
         hq = (longint'(h_raw) * 10000 + 32767) / 65535;
         r.temp = 15'(tq) - 15'd4500;
         r.hum = 14'(hq);
      end
      return r;
   endfunction

   // ---------------- sensor side stimulus ----------------
   function automatic logic sensor_sda();
      case (ph)
         S_ACK_POLL: begin
            case (ack_style)
               ACK_AT_ONCE: return 1'b0;
               ACK_LATE:    return 1'($urandom_range(1));
               default:     return 1'b1;
            endcase
         end
         S_RD_LOW, S_RD_HIGH: begin
            case (data_style)
               BITS_LOW:  return 1'b0;
               BITS_HIGH: return 1'b1;
               default:   return 1'($urandom_range(1));
            endcase
         end
         default: return 1'($urandom_range(1));
      endcase
   endfunction

   task automatic send_tick(input logic start, input logic sda, input logic typed,
                            input bus_result_type want);
      seq_phase_type  prev;
      bus_result_type got;
      int             pick;
      while (!calm && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_start_request <= start;
      req_sda_sample <= sda;
      do @(posedge clock); while (req_stall);
      prev = ph;
      got = advance_sequencer(start, sda);
      pending_bus_states.push_back(typed ? want : got);
      if (ph == S_ACK_POLL && prev != S_ACK_POLL) begin
         pick = $urandom_range(99);
         ack_style = (pick < 65) ? ACK_AT_ONCE : (pick < 88) ? ACK_LATE : ACK_NEVER;
      end
      if (ph == S_START_A && prev != S_START_A) begin
         pick = $urandom_range(3);
         data_style = (pick == 0) ? BITS_LOW : (pick == 1) ? BITS_HIGH : BITS_RANDOM;
      end
      @(negedge clock);
   endtask

   // leaves csr_valid high; the caller lowers it after the last write
   task automatic write_reg(input ihsr_pkg::csr_index_type idx, input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ihsr_pkg::CSR_DEVICE_ADDRESS: cfg.device_address = value[6:0];
         ihsr_pkg::CSR_COMMAND_HIGH:   cfg.command_high = value[7:0];
         ihsr_pkg::CSR_COMMAND_LOW:    cfg.command_low = value[7:0];
         ihsr_pkg::CSR_HALF_PERIOD:    cfg.half_period_ticks = value[15:0];
         ihsr_pkg::CSR_ACK_TIMEOUT:    cfg.ack_timeout = value[7:0];
         ihsr_pkg::CSR_CONV_WAIT:      cfg.conversion_wait_ticks = value;
         ihsr_pkg::CSR_RETRY_WAIT:     cfg.retry_wait_ticks = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic drain(input int settle);
      req_valid <= 1'b0;
      while (pending_bus_states.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // ---------------- result checking ----------------
   task automatic report_mismatch(input string field, input int got, input int want);
      $display("t=%0t %s: got %0d, expected %0d", $realtime, field, got, want);
      mismatch_count++;
   endtask

   always @(negedge clock) rsp_stall <= !calm && ($urandom_range(99) < 37);

   always @(posedge clock) begin
      bus_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bus_states.size() == 0) begin
            report_mismatch("result with no item pending", 1, 0);
         end else begin
            want = pending_bus_states.pop_front();
            if (rsp_clock_line !== want.pins.clock_line)
               report_mismatch("clock_line", rsp_clock_line, want.pins.clock_line);
            if (rsp_data_line !== want.pins.data_line)
               report_mismatch("data_line", rsp_data_line, want.pins.data_line);
            if (rsp_data_drive_enable !== want.pins.data_drive_enable)
               report_mismatch("data_drive_enable", rsp_data_drive_enable,
                               want.pins.data_drive_enable);
            if (rsp_busy_res !== want.pins.busy_res)
               report_mismatch("busy_res", rsp_busy_res, want.pins.busy_res);
            if (rsp_done_res !== want.pins.done_res)
               report_mismatch("done_res", rsp_done_res, want.pins.done_res);
            if (rsp_failed !== want.pins.failed)
               report_mismatch("failed", rsp_failed, want.pins.failed);
            if (rsp_temperature_centi !== want.temp)
               report_mismatch("temperature_centi", $signed(rsp_temperature_centi),
                               $signed(want.temp));
            if (rsp_humidity_centi !== want.hum)
               report_mismatch("humidity_centi", rsp_humidity_centi, want.hum);
         end
      end
   end

   // ---------------- stimulus ----------------
   initial begin
      int          n_items;
      logic [23:0] v_addr, v_cmd_hi, v_cmd_lo, v_half, v_ack_to, v_conv, v_retry;
      logic        start;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset configuration, idle and opening ticks
      for (int i = 0; i < ROWS; i++)
         send_tick(tick_rows[i].start, tick_rows[i].sda, tick_rows[i].typed,
                   '{pins: tick_rows[i].pins, temp: tick_rows[i].temp,
                     hum: tick_rows[i].hum});

      for (int p = 0; p < 8; p++) begin
         drain(4);
         v_addr   = 24'($urandom_range(127));
         v_cmd_hi = 24'($urandom_range(255));
         v_cmd_lo = 24'($urandom_range(255));
         case (p)
            0: begin
               // every register at zero: one-tick segments, first high poll refuses
               v_addr = '0; v_cmd_hi = '0; v_cmd_lo = '0; v_half = '0;
               v_ack_to = '0; v_conv = '0; v_retry = '0;
               n_items = 220;
            end
            1: begin
               v_addr = 24'd127; v_cmd_hi = 24'd255; v_cmd_lo = 24'd255;
               v_half = 24'd1; v_ack_to = 24'd2; v_conv = 24'd3; v_retry = 24'd5;
               n_items = 230;
            end
            2: begin
               // widest durations; the next phase cuts them short mid-sequence
               v_half = 24'hFFFF; v_ack_to = 24'd255;
               v_conv = 24'hFFFFFF; v_retry = 24'hFFFFFF;
               n_items = 40;
            end
            default: begin
               v_half = 24'($urandom_range(2));
               v_ack_to = ($urandom_range(3) == 0) ? 24'd255 : 24'($urandom_range(6));
               v_conv = 24'($urandom_range(30));
               v_retry = 24'($urandom_range(30));
               n_items = 170;
            end
         endcase
         write_reg(ihsr_pkg::CSR_DEVICE_ADDRESS, v_addr);
         write_reg(ihsr_pkg::CSR_COMMAND_HIGH, v_cmd_hi);
         write_reg(ihsr_pkg::CSR_COMMAND_LOW, v_cmd_lo);
         write_reg(ihsr_pkg::CSR_HALF_PERIOD, v_half);
         write_reg(ihsr_pkg::CSR_ACK_TIMEOUT, v_ack_to);
         write_reg(ihsr_pkg::CSR_CONV_WAIT, v_conv);
         write_reg(ihsr_pkg::CSR_RETRY_WAIT, v_retry);
         csr_valid <= 1'b0;
         calm = (p == 4);

         for (int i = 0; i < n_items; i++) begin
            if (ph == S_IDLE || ph == S_DONE || ph == S_FAIL)
               start = 1'($urandom_range(1));
            else
               start = ($urandom_range(4) == 0);
            send_tick(start, sensor_sda(), 1'b0, '0);
         end
         calm = 1'b0;
      end

      drain(10);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
`default_nettype wire
